FILE: design/onewire_thermometer_device_core_macros.svh
// assertion macros for the thermometer device core checker
`ifndef ONEWIRE_THERMOMETER_DEVICE_CORE_MACROS_SVH
`define ONEWIRE_THERMOMETER_DEVICE_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define OWTD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("owtd assertion failed");

// antecedent implies consequent in the next cycle
`define OWTD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("owtd assertion failed");

`endif

FILE: design/owtd_pkg.sv
// shared types, codes and helper functions for the thermometer device core
package owtd_pkg;

	localparam int TIME_BITS_DEF = 40;
	localparam int NOW_W         = 40;
	localparam int SCR_DEPTH     = 9;
	localparam int SCR_AW        = $clog2(SCR_DEPTH);
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;

	// function codes of a request
	localparam logic [1:0] F_CMD   = 2'd0;
	localparam logic [1:0] F_WRITE = 2'd1;
	localparam logic [1:0] F_READ  = 2'd2;

	// function commands
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_SP  = 8'hBE;
	localparam logic [7:0] CMD_WRITE_SP = 8'h4E;
	localparam logic [7:0] CMD_COPY_SP  = 8'h48;
	localparam logic [7:0] CMD_RECALL   = 8'hB8;
	localparam logic [7:0] CMD_POWER    = 8'hB4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POWER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CFGRES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_TH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_TL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_RS = 3'd4;

	localparam logic [19:0] CONV_T0 = 20'd90000;
	localparam logic [19:0] CONV_T1 = 20'd180000;
	localparam logic [19:0] CONV_T2 = 20'd360000;
	localparam logic [19:0] CONV_T3 = 20'd720000;

	localparam logic signed [15:0] TEMP_MIN = -16'sd14080;
	localparam logic signed [15:0] TEMP_MAX = 16'sd32000;

	typedef struct packed {
		logic [1:0]         func;
		logic [7:0]         command_byte;
		logic               bit_value;
		logic [6:0]         bit_index;
		logic [NOW_W-1:0]   now_us;
		logic signed [15:0] sample_temp;
	} in_item_t;

	typedef struct packed {
		logic bit_out;
		logic alarm;
	} out_item_t;

	// one byte of the dallas crc-8, lsb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ b[k]) begin
				c = (c >> 1) ^ 8'h8C;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// scratchpad contents after reset, bytes 0..7
	function automatic logic [7:0] scr_init(input logic [2:0] idx, input logic [7:0] th,
			input logic [7:0] tl);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'hAA;
			3'd1: r = 8'h00;
			3'd2: r = th;
			3'd3: r = tl;
			3'd4: r = 8'hFF;
			3'd5: r = 8'hFF;
			3'd6: r = 8'h0C;
			3'd7: r = 8'h10;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] res_byte(input logic [3:0] r);
		return {1'b0, r[1:0] + 2'd3, 5'h1F};
	endfunction

endpackage

FILE: design/owtd_ram.sv
// generic single-write, single-read ram with registered read data
module owtd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/onewire_thermometer_device_core.sv
// function layer of a 1-wire thermometer with scratchpad ram and crc sequencer
//  channel | direction | handshake         | payload
//  in      | into core | in_valid/in_stall   | owtd_pkg::in_item_t
//  out     | from core | out_valid/out_stall | owtd_pkg::out_item_t
//  cfg     | into core | cfg_we              | cfg_index, cfg_data
// one request at a time through a sequencer over the 9-byte scratchpad ram
// the longest request is a command that finishes a conversion, then recalls
// each crc pass does one ram read per byte
// after reset an init pass loads the scratchpad and runs a crc pass, requests wait
// a th/tl register write adds a ram write and crc pass before the next request
// a finished request waits in the sequencer while the output register is still full
module onewire_thermometer_device_core #(
	parameter int TIME_BITS = owtd_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  owtd_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output owtd_pkg::out_item_t                 out_item,
	input  logic                                cfg_we,
	input  logic [owtd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [owtd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = owtd_pkg::SCR_AW;

	localparam logic [4:0] ST_INIT      = 5'd0;
	localparam logic [4:0] ST_IDLE      = 5'd1;
	localparam logic [4:0] ST_CRC_START = 5'd2;
	localparam logic [4:0] ST_CRC_LOOP  = 5'd3;
	localparam logic [4:0] ST_CRC_WB    = 5'd4;
	localparam logic [4:0] ST_CHK_RD    = 5'd5;
	localparam logic [4:0] ST_CHK_EV    = 5'd6;
	localparam logic [4:0] ST_FIN_W0    = 5'd7;
	localparam logic [4:0] ST_FIN_W1    = 5'd8;
	localparam logic [4:0] ST_FIN_W6    = 5'd9;
	localparam logic [4:0] ST_FIN_R2    = 5'd10;
	localparam logic [4:0] ST_FIN_R3    = 5'd11;
	localparam logic [4:0] ST_FIN_AL    = 5'd12;
	localparam logic [4:0] ST_CMD       = 5'd13;
	localparam logic [4:0] ST_CP_R2     = 5'd14;
	localparam logic [4:0] ST_CP_R3     = 5'd15;
	localparam logic [4:0] ST_CP_R4     = 5'd16;
	localparam logic [4:0] ST_CP_D      = 5'd17;
	localparam logic [4:0] ST_RC_W2     = 5'd18;
	localparam logic [4:0] ST_RC_W3     = 5'd19;
	localparam logic [4:0] ST_RC_W4     = 5'd20;
	localparam logic [4:0] ST_WB_RD     = 5'd21;
	localparam logic [4:0] ST_WB_WR     = 5'd22;
	localparam logic [4:0] ST_RD_RD     = 5'd23;
	localparam logic [4:0] ST_RD_D      = 5'd24;
	localparam logic [4:0] ST_DONE      = 5'd25;

	logic [4:0]            state_q, ret_q, chk_ret_q;
	logic [2:0]            cnt_q;
	logic [7:0]            crc_q;
	owtd_pkg::in_item_t    item_q;
	logic                  bit_q;
	logic [7:0]            th_q;
	logic                  power_q, cfgres_q;
	logic [7:0]            init_th_q, init_tl_q;
	logic                  pend_th_q, pend_tl_q;
	logic [7:0]            ee0_q, ee1_q, ee2_q;
	logic [7:0]            active_q;
	logic                  converting_q;
	logic [TIME_BITS-1:0]  start_q;
	logic signed [15:0]    held_q;
	logic                  alarm_q;
	logic                  out_valid_q;
	owtd_pkg::out_item_t   out_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [7:0]            mem_wdata, rd_data;

	logic                  accept;
	logic [TIME_BITS-1:0]  now_t, elapsed;
	logic [19:0]           conv_t;
	logic signed [15:0]    v_c, t16, t128, whole, rem, t_r;
	logic [7:0]            enc0, enc1, enc6;
	logic signed [15:0]    th_ext, tl_ext;
	logic [7:0]            wb_byte;

	owtd_ram #(
		.WIDTH(8),
		.DEPTH(owtd_pkg::SCR_DEPTH)
	) u_scr (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	assign in_stall  = !(state_q == ST_IDLE && !pend_th_q && !pend_tl_q);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign now_t   = TIME_BITS'(item_q.now_us);
	assign elapsed = now_t - start_q;

	always_comb begin
		case (rd_data[6:5])
			2'd0: conv_t = owtd_pkg::CONV_T0;
			2'd1: conv_t = owtd_pkg::CONV_T1;
			2'd2: conv_t = owtd_pkg::CONV_T2;
			default: conv_t = owtd_pkg::CONV_T3;
		endcase
		if (!cfgres_q) begin
			conv_t = owtd_pkg::CONV_T3;
		end
	end

	// clamp and encode the held sample, divisions truncate toward zero
	always_comb begin
		if (held_q < owtd_pkg::TEMP_MIN) begin
			v_c = owtd_pkg::TEMP_MIN;
		end else if (held_q > owtd_pkg::TEMP_MAX) begin
			v_c = owtd_pkg::TEMP_MAX;
		end else begin
			v_c = held_q;
		end
		t16   = v_c[15] ? ((v_c + 16'sd15) >>> 4) : (v_c >>> 4);
		t128  = v_c[15] ? ((v_c + 16'sd127) >>> 7) : (v_c >>> 7);
		whole = v_c[15] ? ((v_c + 16'sd255) >>> 8) : (v_c >>> 8);
		rem   = v_c - (whole <<< 8);
		t_r   = rem[15] ? ((rem + 16'sd15) >>> 4) : (rem >>> 4);
		if (cfgres_q) begin
			enc0 = t16[7:0];
			enc1 = t16[15:8];
		end else begin
			enc0 = t128[7:0];
			enc1 = v_c[15] ? 8'hFF : 8'h00;
		end
		enc6   = t_r[7:0];
		th_ext = {{8{th_q[7]}}, th_q};
		tl_ext = {{8{rd_data[7]}}, rd_data};
	end

	always_comb begin
		wb_byte = rd_data;
		wb_byte[item_q.bit_index[2:0]] = item_q.bit_value;
	end

	// ram port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(cnt_q);
				mem_wdata = owtd_pkg::scr_init(cnt_q, init_th_q, init_tl_q);
			end
			ST_IDLE: begin
				mem_we    = pend_th_q || pend_tl_q;
				mem_waddr = pend_th_q ? AW'(2) : AW'(3);
				mem_wdata = pend_th_q ? init_th_q : init_tl_q;
			end
			ST_CRC_START: mem_raddr = AW'(0);
			ST_CRC_LOOP:  mem_raddr = AW'(cnt_q + 3'd1);
			ST_CRC_WB: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(8);
				mem_wdata = crc_q;
			end
			ST_CHK_RD: mem_raddr = AW'(4);
			ST_FIN_W0: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(0);
				mem_wdata = enc0;
			end
			ST_FIN_W1: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(1);
				mem_wdata = enc1;
			end
			ST_FIN_W6: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(6);
				mem_wdata = enc6;
			end
			ST_FIN_R2: mem_raddr = AW'(2);
			ST_FIN_R3: mem_raddr = AW'(3);
			ST_CP_R2:  mem_raddr = AW'(2);
			ST_CP_R3:  mem_raddr = AW'(3);
			ST_CP_R4:  mem_raddr = AW'(4);
			ST_RC_W2: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(2);
				mem_wdata = ee0_q;
			end
			ST_RC_W3: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(3);
				mem_wdata = ee1_q;
			end
			ST_RC_W4: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(4);
				mem_wdata = ee2_q;
			end
			ST_WB_RD: mem_raddr = AW'({2'b00, item_q.bit_index[4:3]} + 4'd2);
			ST_WB_WR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'({2'b00, item_q.bit_index[4:3]} + 4'd2);
				mem_wdata = wb_byte;
			end
			ST_RD_RD: mem_raddr = AW'(item_q.bit_index[6:3]);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			ret_q        <= ST_IDLE;
			chk_ret_q    <= ST_DONE;
			cnt_q        <= '0;
			power_q      <= 1'b1;
			cfgres_q     <= 1'b1;
			init_th_q    <= 8'd75;
			init_tl_q    <= 8'd70;
			pend_th_q    <= 1'b0;
			pend_tl_q    <= 1'b0;
			ee0_q        <= 8'd75;
			ee1_q        <= 8'd70;
			ee2_q        <= owtd_pkg::res_byte(4'd12);
			active_q     <= '0;
			converting_q <= 1'b0;
			start_q      <= '0;
			held_q       <= '0;
			alarm_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						ret_q   <= ST_IDLE;
						state_q <= ST_CRC_START;
					end
				end
				ST_IDLE: begin
					if (pend_th_q) begin
						pend_th_q <= 1'b0;
						ret_q     <= ST_IDLE;
						state_q   <= ST_CRC_START;
					end else if (pend_tl_q) begin
						pend_tl_q <= 1'b0;
						ret_q     <= ST_IDLE;
						state_q   <= ST_CRC_START;
					end else if (accept) begin
						case (in_item.func)
							owtd_pkg::F_CMD: begin
								chk_ret_q <= ST_CMD;
								state_q   <= ST_CHK_RD;
							end
							owtd_pkg::F_WRITE: begin
								if (active_q == owtd_pkg::CMD_WRITE_SP
										&& in_item.bit_index < 7'd24) begin
									state_q <= ST_WB_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							owtd_pkg::F_READ: begin
								if (active_q == owtd_pkg::CMD_READ_SP) begin
									state_q <= (in_item.bit_index < 7'd72) ? ST_RD_RD : ST_DONE;
								end else if (active_q == owtd_pkg::CMD_CONVERT && power_q) begin
									chk_ret_q <= ST_DONE;
									state_q   <= ST_CHK_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_CRC_START: begin
					crc_q   <= 8'h00;
					cnt_q   <= '0;
					state_q <= ST_CRC_LOOP;
				end
				ST_CRC_LOOP: begin
					crc_q <= owtd_pkg::crc8_byte(crc_q, rd_data);
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= ST_CRC_WB;
					end
				end
				ST_CRC_WB: state_q <= ret_q;
				ST_CHK_RD: state_q <= converting_q ? ST_CHK_EV : chk_ret_q;
				ST_CHK_EV: begin
					state_q <= (elapsed >= TIME_BITS'(conv_t)) ? ST_FIN_W0 : chk_ret_q;
				end
				ST_FIN_W0: state_q <= ST_FIN_W1;
				ST_FIN_W1: state_q <= cfgres_q ? ST_FIN_R2 : ST_FIN_W6;
				ST_FIN_W6: state_q <= ST_FIN_R2;
				ST_FIN_R2: state_q <= ST_FIN_R3;
				ST_FIN_R3: begin
					th_q    <= rd_data;
					state_q <= ST_FIN_AL;
				end
				ST_FIN_AL: begin
					alarm_q      <= (whole >= th_ext) || (whole <= tl_ext);
					converting_q <= 1'b0;
					start_q      <= '0;
					ret_q        <= chk_ret_q;
					state_q      <= ST_CRC_START;
				end
				ST_CMD: begin
					active_q <= item_q.command_byte;
					case (item_q.command_byte)
						owtd_pkg::CMD_CONVERT: begin
							held_q       <= item_q.sample_temp;
							converting_q <= 1'b1;
							start_q      <= now_t;
							state_q      <= ST_DONE;
						end
						owtd_pkg::CMD_COPY_SP: state_q <= ST_CP_R2;
						owtd_pkg::CMD_RECALL:  state_q <= ST_RC_W2;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_CP_R2: state_q <= ST_CP_R3;
				ST_CP_R3: begin
					ee0_q   <= rd_data;
					state_q <= ST_CP_R4;
				end
				ST_CP_R4: begin
					ee1_q   <= rd_data;
					state_q <= ST_CP_D;
				end
				ST_CP_D: begin
					if (cfgres_q) begin
						ee2_q <= rd_data;
					end
					state_q <= ST_DONE;
				end
				ST_RC_W2: state_q <= ST_RC_W3;
				ST_RC_W3: begin
					ret_q   <= ST_DONE;
					state_q <= cfgres_q ? ST_RC_W4 : ST_CRC_START;
				end
				ST_RC_W4: state_q <= ST_CRC_START;
				ST_WB_RD: state_q <= ST_WB_WR;
				ST_WB_WR: begin
					ret_q   <= ST_DONE;
					state_q <= ST_CRC_START;
				end
				ST_RD_RD: state_q <= ST_RD_D;
				ST_RD_D:  state_q <= ST_DONE;
				ST_DONE: begin
					// hold the result until the output register is free
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// idle-only register writes are the user's duty; after sequencer updates
			if (cfg_we) begin
				case (cfg_index)
					owtd_pkg::CFG_POWER:  power_q  <= cfg_data[0];
					owtd_pkg::CFG_CFGRES: cfgres_q <= cfg_data[0];
					owtd_pkg::CFG_INIT_TH: begin
						init_th_q <= cfg_data;
						ee0_q     <= cfg_data;
						pend_th_q <= 1'b1;
					end
					owtd_pkg::CFG_INIT_TL: begin
						init_tl_q <= cfg_data;
						ee1_q     <= cfg_data;
						pend_tl_q <= 1'b1;
					end
					owtd_pkg::CFG_INIT_RS: ee2_q <= owtd_pkg::res_byte(cfg_data[3:0]);
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
			bit_q  <= (in_item.func == owtd_pkg::F_READ && active_q == owtd_pkg::CMD_POWER)
				? power_q : 1'b1;
		end else if (state_q == ST_RD_D) begin
			bit_q <= rd_data[item_q.bit_index[2:0]];
		end
		if (state_q == ST_DONE && !out_valid_q) begin
			out_q.bit_out <= (item_q.func == owtd_pkg::F_READ
				&& active_q == owtd_pkg::CMD_CONVERT && power_q) ? !converting_q : bit_q;
			out_q.alarm   <= alarm_q;
		end
	end

endmodule

FILE: design/owtd_checker.sv
// port-level checker for the thermometer device core, bound to the top level
`include "onewire_thermometer_device_core_macros.svh"

module owtd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input owtd_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_stall,
	input owtd_pkg::out_item_t out_item
);

	// a stalled result holds
	`OWTD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

	// one request at a time: the core stalls right after taking one
	`OWTD_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

	// a taken result is never followed at once by another
	`OWTD_ASSERT_NEXT(a_no_extra_result, out_valid && !out_stall, !out_valid)

	// handshake outputs are always driven out of reset
	`OWTD_ASSERT_NOW(a_handshake_known, 1'b1, !$isunknown({in_stall, out_valid}))

endmodule

bind onewire_thermometer_device_core owtd_checker u_owtd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_item  (in_item),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item (out_item)
);

FILE: tb/onewire_thermometer_device_core_checker.sv
// checker for the thermometer device core: tracks accepted requests, predicts and compares
`timescale 1ns / 100ps

module onewire_thermometer_device_core_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  owtd_pkg::in_item_t                  in_item,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  owtd_pkg::out_item_t                 out_item,
	input  logic                                cfg_we,
	input  logic [owtd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [owtd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  fail_count,
	output int                                  pending_count
);
	import owtd_pkg::*;

	logic [7:0]  sp [0:8];
	logic [7:0]  ee [0:2];
	logic [7:0]  cur_cmd;
	logic        busy_conv;
	logic [39:0] conv_t0;
	logic [15:0] latched_temp;
	logic        alarm_q;
	logic        pwr;
	logic        res_sel;
	out_item_t   bit_results [$];

	function automatic logic [7:0] res_code(input logic [3:0] r);
		logic [1:0] lo;
		lo = r[1:0] + 2'd3;
		return {1'b0, lo, 5'h1F};
	endfunction

	task automatic refresh_crc();
		logic [7:0] c;
		logic [7:0] b;
		c = 8'h00;
		for (int i = 0; i < 8; i++) begin
			b = sp[i];
			for (int k = 0; k < 8; k++) begin
				if (c[0] ^ b[k]) begin
					c = (c >> 1) ^ 8'h8C;
				end else begin
					c = c >> 1;
				end
			end
		end
		sp[8] = c;
	endtask

	function automatic logic [39:0] conv_length();
		if (!res_sel) begin
			return 40'd720000;
		end
		case (sp[4][6:5])
			2'd0: return 40'd90000;
			2'd1: return 40'd180000;
			2'd2: return 40'd360000;
			default: return 40'd720000;
		endcase
	endfunction

	task automatic finish_conversion(input logic [39:0] now);
		int v;
		int whole;
		int t;
		if (!busy_conv || (now - conv_t0) < conv_length()) begin
			return;
		end
		busy_conv = 1'b0;
		conv_t0 = '0;
		v = $signed(latched_temp);
		if (v < -14080) begin
			v = -14080;
		end else if (v > 32000) begin
			v = 32000;
		end
		if (res_sel) begin
			t = v / 16;
			sp[0] = t[7:0];
			sp[1] = t[15:8];
		end else begin
			t = v / 128;
			sp[0] = t[7:0];
			sp[1] = (v >= 0) ? 8'h00 : 8'hFF;
			t = (v % 256) / 16;
			sp[6] = t[7:0];
		end
		refresh_crc();
		whole = v / 256;
		alarm_q = (whole >= $signed(sp[2])) || (whole <= $signed(sp[3]));
	endtask

	task automatic model_request(input in_item_t r);
		out_item_t o;
		o.bit_out = 1'b1;
		if (r.func == F_CMD) begin
			finish_conversion(r.now_us);
			cur_cmd = r.command_byte;
			if (r.command_byte == CMD_CONVERT) begin
				latched_temp = r.sample_temp;
				busy_conv = 1'b1;
				conv_t0 = r.now_us;
			end else if (r.command_byte == CMD_COPY_SP) begin
				ee[0] = sp[2];
				ee[1] = sp[3];
				if (res_sel) begin
					ee[2] = sp[4];
				end
			end else if (r.command_byte == CMD_RECALL) begin
				sp[2] = ee[0];
				sp[3] = ee[1];
				if (res_sel) begin
					sp[4] = ee[2];
				end
				refresh_crc();
			end
		end else if (r.func == F_WRITE) begin
			if (cur_cmd == CMD_WRITE_SP && r.bit_index < 7'd24) begin
				sp[2 + r.bit_index[4:3]][r.bit_index[2:0]] = r.bit_value;
				refresh_crc();
			end
		end else if (r.func == F_READ) begin
			if (cur_cmd == CMD_READ_SP) begin
				if (r.bit_index < 7'd72) begin
					o.bit_out = sp[r.bit_index[6:3]][r.bit_index[2:0]];
				end
			end else if (cur_cmd == CMD_POWER) begin
				o.bit_out = pwr;
			end else if (cur_cmd == CMD_CONVERT && pwr) begin
				finish_conversion(r.now_us);
				o.bit_out = !busy_conv;
			end
		end
		o.alarm = alarm_q;
		bit_results.push_back(o);
	endtask

	task automatic report(input string what, input logic got, input logic want);
		$display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pwr = 1'b1;
		res_sel = 1'b1;
		ee[0] = 8'd75;
		ee[1] = 8'd70;
		ee[2] = res_code(4'd12);
		sp[0] = 8'hAA; sp[1] = 8'h00; sp[2] = ee[0]; sp[3] = ee[1];
		sp[4] = 8'hFF; sp[5] = 8'hFF; sp[6] = 8'h0C; sp[7] = 8'h10;
		refresh_crc();
		cur_cmd = '0;
		busy_conv = 1'b0;
		conv_t0 = '0;
		latched_temp = '0;
		alarm_q = 1'b0;
	end

	assign pending_count = bit_results.size();

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_POWER: pwr = cfg_data[0];
					CFG_CFGRES: res_sel = cfg_data[0];
					CFG_INIT_TH: begin
						ee[0] = cfg_data;
						sp[2] = cfg_data;
						refresh_crc();
					end
					CFG_INIT_TL: begin
						ee[1] = cfg_data;
						sp[3] = cfg_data;
						refresh_crc();
					end
					CFG_INIT_RS: ee[2] = res_code(cfg_data[3:0]);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (bit_results.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					fail_count++;
				end else begin
					want = bit_results.pop_front();
					if (out_item.bit_out !== want.bit_out) begin
						report("bit_out", out_item.bit_out, want.bit_out);
					end
					if (out_item.alarm !== want.alarm) begin
						report("alarm", out_item.alarm, want.alarm);
					end
				end
			end
			if (in_valid && !in_stall) begin
				model_request(in_item);
			end
		end
	end
endmodule

FILE: tb/tb_onewire_thermometer_device_core.sv
// testbench top for the thermometer device core: stimulus, configuration and verdict
`timescale 1ns / 100ps

module tb_onewire_thermometer_device_core;
	import owtd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending_count;
	int                    cycle_count;
	logic [39:0]           bus_time;

	onewire_thermometer_device_core i_dut (.*);

	onewire_thermometer_device_core_checker i_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout");
			$display("** onewire_thermometer_device_core: FAILED **");
			$finish;
		end
	end

	// receiver stall, new draw per result
	initial begin
		int gap;
		out_stall = 1'b0;
		forever begin
			gap = $urandom_range(0, 6);
			if (($urandom_range(0, 3) == 0)) begin
				gap = 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// starts and ends at a falling edge; valid stays up when the next request follows at once
	task automatic send(input logic [1:0] f, input logic [7:0] c, input logic b,
			input logic [6:0] idx, input logic [15:0] temp);
		in_item_t r;
		int gap;
		logic [95:0] junk;
		gap = $urandom_range(0, 6);
		if (($urandom_range(0, 3) == 0)) begin
			gap = 0;
		end
		if (gap > 0) begin
			junk = {$urandom, $urandom, $urandom};
			in_valid <= 1'b0;
			in_item <= junk[$bits(in_item_t)-1:0];
			repeat (gap) @(negedge clk);
		end
		r.func = f;
		r.command_byte = c;
		r.bit_value = b;
		r.bit_index = idx;
		r.now_us = bus_time;
		r.sample_temp = temp;
		in_item <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		// advance bus time so conversions sometimes finish
		case ($urandom_range(0, 3))
			0: bus_time = bus_time + 40'd70;
			1: bus_time = bus_time + $urandom_range(0, 200000);
			2: bus_time = bus_time + 40'd720000;
			default: begin
				junk = {$urandom, $urandom, $urandom};
				bus_time = junk[39:0];
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_temp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(-14080 + $urandom_range(0, 1));
			3: return 16'(32000 - $urandom_range(0, 1));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(input int count);
		int sel;
		logic [7:0] cmds [6];
		cmds = '{CMD_CONVERT, CMD_READ_SP, CMD_WRITE_SP, CMD_COPY_SP, CMD_RECALL, CMD_POWER};
		for (int n = 0; n < count; ) begin
			sel = $urandom_range(0, 9);
			if (sel < 2) begin
				// convert, then poll
				send(F_CMD, CMD_CONVERT, 1'b0, 7'd0, pick_temp());
				repeat ($urandom_range(1, 3)) send(F_READ, 8'h00, 1'b0, 7'($urandom), 16'h0);
				n += 3;
			end else if (sel < 4) begin
				send(F_CMD, CMD_WRITE_SP, 1'b0, 7'd0, 16'h0);
				for (int i = 0; i < 24; i++) begin
					send(F_WRITE, 8'($urandom), 1'($urandom), 7'(i), 16'($urandom));
				end
				if ($urandom_range(0, 1)) begin
					send(F_WRITE, 8'h00, 1'($urandom), 7'($urandom_range(24, 127)), 16'h0);
				end
				n += 25;
			end else if (sel < 6) begin
				send(F_CMD, CMD_READ_SP, 1'b0, 7'd0, 16'h0);
				for (int i = 0; i < 72; i += $urandom_range(1, 4)) begin
					send(F_READ, 8'($urandom), 1'($urandom), 7'(i), 16'($urandom));
				end
				send(F_READ, 8'h00, 1'b0, 7'($urandom_range(72, 127)), 16'h0);
				n += 30;
			end else if (sel < 8) begin
				send(F_CMD, cmds[$urandom_range(0, 5)], 1'b0, 7'd0, pick_temp());
				send(F_READ, 8'h00, 1'b0, 7'($urandom), 16'h0);
				n += 2;
			end else begin
				send(2'($urandom), 8'($urandom), 1'($urandom), 7'($urandom), 16'($urandom));
				n += 1;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cycle_count = 0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bus_time = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed
		send(F_READ, CMD_READ_SP, 1'b1, 7'd0, 16'h0);
		send(F_CMD, CMD_READ_SP, 1'b0, 7'd0, 16'h0);
		send(F_READ, 8'h00, 1'b0, 7'd0, 16'h0);
		send(F_READ, 8'h00, 1'b0, 7'd71, 16'h0);
		send(F_READ, 8'h00, 1'b0, 7'd127, 16'h0);
		send(F_CMD, CMD_POWER, 1'b0, 7'd0, 16'h0);
		send(F_READ, 8'h00, 1'b0, 7'd5, 16'h0);
		send(F_CMD, CMD_CONVERT, 1'b0, 7'd0, 16'h7FFF);
		send(F_READ, 8'h00, 1'b0, 7'd0, 16'h0);
		send(F_CMD, CMD_CONVERT, 1'b0, 7'd0, 16'h8000);
		bus_time = bus_time + 40'd720000;
		send(F_READ, 8'h00, 1'b0, 7'd0, 16'h0);
		send(F_CMD, CMD_WRITE_SP, 1'b0, 7'd0, 16'h0);
		send(F_WRITE, 8'h00, 1'b0, 7'd0, 16'h0);
		send(F_WRITE, 8'h00, 1'b1, 7'd23, 16'h0);
		send(F_WRITE, 8'h00, 1'b1, 7'd24, 16'h0);
		send(F_WRITE, 8'h00, 1'b1, 7'd127, 16'h0);
		send(F_CMD, CMD_COPY_SP, 1'b0, 7'd0, 16'h0);
		send(F_CMD, CMD_RECALL, 1'b0, 7'd0, 16'h0);
		send(2'd3, 8'hFF, 1'b1, 7'd127, 16'hFFFF);
		bus_time = 40'hFF_FFFF_FFF0;
		send(F_CMD, CMD_CONVERT, 1'b0, 7'd0, 16'hFF00);
		bus_time = 40'd800000;
		send(F_CMD, CMD_READ_SP, 1'b0, 7'd0, 16'h0);
		drain();

		random_phase(100);
		drain();
		write_reg(CFG_POWER, 8'd0);
		write_reg(CFG_CFGRES, 8'd0);
		write_reg(CFG_INIT_TH, 8'h7F);
		write_reg(CFG_INIT_TL, 8'h80);
		write_reg(CFG_INIT_RS, 8'd9);
		repeat (40) @(negedge clk);
		random_phase(100);
		drain();
		write_reg(CFG_POWER, 8'd1);
		write_reg(CFG_CFGRES, 8'd1);
		write_reg(CFG_INIT_TH, 8'h80);
		write_reg(CFG_INIT_TL, 8'h7F);
		write_reg(CFG_INIT_RS, 8'd10);
		repeat (40) @(negedge clk);
		random_phase(100);
		drain();
		write_reg(CFG_INIT_TH, 8'($urandom_range(0, 40)));
		write_reg(CFG_INIT_TL, 8'($urandom_range(200, 255)));
		write_reg(CFG_INIT_RS, 8'd11);
		write_reg(CFG_POWER, 8'd0);
		repeat (40) @(negedge clk);
		random_phase(100);
		drain();

		if (fail_count == 0) begin
			$display("** onewire_thermometer_device_core: PASSED **");
		end else begin
			$display("** onewire_thermometer_device_core: FAILED **");
		end
		$finish;
	end
endmodule
